// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
    localparam int TAB_STOP     = 8;

    // Field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = CHAR_W + 2 * CLR_W;
    localparam int CFG_W  = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

    // Configuration register indexes and reset values
    localparam logic [CFG_W-1:0] CFG_BLANK_FG = 1'b0;
    localparam logic [CFG_W-1:0] CFG_BLANK_BG = 1'b1;
    localparam logic [CLR_W-1:0] RESET_BLANK_FG = 4'd15;
    localparam logic [CLR_W-1:0] RESET_BLANK_BG = 4'd1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec_put;
        logic clear_cursor;
        logic issue_read;
        logic scroll_step;
        logic fill_step;
        logic fill_reset_blank;
        logic cnt_zero;
        logic cnt_inc;
        logic load_out;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            need_scroll;
        logic            scroll_end;
        logic            fill_end;
    } t_dp_sts;

    // Linear cell index of a cursor position
    function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_index = IDX_W'(row) * IDX_W'(COLUMNS) + IDX_W'(col);
    endfunction

endpackage

// ===== hdl/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: 80x25 cell screen with cursor, put/clear/read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction: op,
//   char_code, colors and read_index. Output channel (o_out_valid /
//   i_out_stall) returns one result per transaction: cursor address and,
//   for a read, the cell contents (zero otherwise).
//   Config channel (i_cfg_valid / o_cfg_ready) sets the blank colors used
//   by scroll and clear; write it only while the block is idle.
//   A put that scrolls copies the rows up and then fills the bottom row;
//   a clear fills the whole screen. These sweeps go one cell per cycle;
//   one transaction is in work at a time, so the next one is accepted
//   only once the last result has been loaded into the output register.
//   Reset: a pass blanks the screen in the reset colors; input stays
//   stalled until it completes.
//   A stalled result stays in the output register; the next transaction is
//   accepted and executed meanwhile, then waits until the register frees.
// ----------------------------------------------------------------------------
module text_console_writer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tcw_pkg::OP_W-1:0]      i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::CLR_W-1:0]     i_fg_color,
    input  logic [tcw_pkg::CLR_W-1:0]     i_bg_color,
    input  logic [tcw_pkg::IDX_W-1:0]     i_read_index,
    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcw_pkg::IDX_W-1:0]     o_cursor_addr,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_line,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_char,
    output logic [tcw_pkg::CLR_W-1:0]     o_read_fg,
    output logic [tcw_pkg::CLR_W-1:0]     o_read_bg,
    // Configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::CFG_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::CLR_W-1:0]     i_cfg_data
);

    tcw_pkg::t_dp_cmd cmd;
    tcw_pkg::t_dp_sts sts;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    tcw_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tcw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_char_code   (i_char_code),
        .i_fg_color    (i_fg_color),
        .i_bg_color    (i_bg_color),
        .i_read_index  (i_read_index),
        .o_cursor_addr (o_cursor_addr),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_line (o_cursor_line),
        .o_read_char   (o_read_char),
        .o_read_fg     (o_read_fg),
        .o_read_bg     (o_read_bg)
    );

endmodule

// ===== hdl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, blank colors, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcw_pkg::t_dp_cmd              i_cmd,
    output tcw_pkg::t_dp_sts              o_sts,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_W-1:0]     i_cfg_index,
    input  logic [tcw_pkg::CLR_W-1:0]     i_cfg_data,
    input  logic [tcw_pkg::OP_W-1:0]      i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::CLR_W-1:0]     i_fg_color,
    input  logic [tcw_pkg::CLR_W-1:0]     i_bg_color,
    input  logic [tcw_pkg::IDX_W-1:0]     i_read_index,
    output logic [tcw_pkg::IDX_W-1:0]     o_cursor_addr,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_line,
    output logic [tcw_pkg::CHAR_W-1:0]    o_read_char,
    output logic [tcw_pkg::CLR_W-1:0]     o_read_fg,
    output logic [tcw_pkg::CLR_W-1:0]     o_read_bg
);

    // Item registers
    logic [tcw_pkg::OP_W-1:0]   r_op;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic [tcw_pkg::CLR_W-1:0]  r_fg;
    logic [tcw_pkg::CLR_W-1:0]  r_bg;
    logic [tcw_pkg::IDX_W-1:0]  r_ridx;

    // Cursor, blank colors, sweep counter
    logic [tcw_pkg::COL_W-1:0]  r_col;
    logic [tcw_pkg::ROW_W-1:0]  r_row;
    logic [tcw_pkg::CLR_W-1:0]  r_blank_fg;
    logic [tcw_pkg::CLR_W-1:0]  r_blank_bg;
    logic [tcw_pkg::IDX_W-1:0]  r_cnt;
    logic [tcw_pkg::IDX_W-1:0]  n_cnt;

    // Screen memory
    logic [tcw_pkg::CELL_W-1:0] r_screen [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rd;
    logic                       mem_we;
    logic [tcw_pkg::IDX_W-1:0]  mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [tcw_pkg::IDX_W-1:0]  mem_raddr;

    // Put decode
    logic [tcw_pkg::COL_W:0]    put_col;
    logic [tcw_pkg::ROW_W:0]    put_row;
    logic                       put_wr;
    logic                       need_scroll;
    logic                       read_ok;

    // Result registers
    logic [tcw_pkg::IDX_W-1:0]  r_out_pos;
    logic [tcw_pkg::COL_W-1:0]  r_out_col;
    logic [tcw_pkg::ROW_W-1:0]  r_out_line;
    logic [tcw_pkg::CHAR_W-1:0] r_out_char;
    logic [tcw_pkg::CLR_W-1:0]  r_out_fg;
    logic [tcw_pkg::CLR_W-1:0]  r_out_bg;

    assign read_ok = (r_ridx < tcw_pkg::IDX_W'(tcw_pkg::CELLS));

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_char <= i_char_code;
            r_fg   <= i_fg_color;
            r_bg   <= i_bg_color;
            r_ridx <= i_read_index;
        end
    end

    // Next cursor for a put
    always_comb begin
        put_col = {1'b0, r_col};
        put_row = {1'b0, r_row};
        put_wr  = 1'b0;
        case (r_char)
            tcw_pkg::CODE_BS: begin
                if (r_col != '0) begin
                    put_col = {1'b0, r_col - tcw_pkg::COL_W'(1)};
                end
            end
            tcw_pkg::CODE_TAB: begin
                put_col = ({1'b0, r_col} + (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_STOP))
                          & ~((tcw_pkg::COL_W+1)'(tcw_pkg::TAB_STOP - 1));
            end
            tcw_pkg::CODE_CR: begin
                put_col = '0;
            end
            tcw_pkg::CODE_LF: begin
                put_col = '0;
                put_row = put_row + (tcw_pkg::ROW_W+1)'(1);
            end
            default: begin
                if (r_char >= tcw_pkg::CODE_SPACE) begin
                    put_wr  = 1'b1;
                    put_col = put_col + (tcw_pkg::COL_W+1)'(1);
                end
            end
        endcase
        // Wrap past the last column
        if (put_col >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)) begin
            put_col = '0;
            put_row = put_row + (tcw_pkg::ROW_W+1)'(1);
        end
        need_scroll = (put_row >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));
    end

    // Cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.clear_cursor) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.exec_put) begin
            r_col <= put_col[tcw_pkg::COL_W-1:0];
            r_row <= need_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                 : put_row[tcw_pkg::ROW_W-1:0];
        end
    end

    // Blank color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_fg <= tcw_pkg::RESET_BLANK_FG;
            r_blank_bg <= tcw_pkg::RESET_BLANK_BG;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcw_pkg::CFG_BLANK_FG: r_blank_fg <= i_cfg_data;
                tcw_pkg::CFG_BLANK_BG: r_blank_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sweep counter for scroll, clear and the reset pass
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_zero) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + tcw_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Memory write port: put cell, scroll copy or blank fill
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = {r_bg, r_fg, r_char};
        if (i_cmd.exec_put && put_wr) begin
            mem_we    = 1'b1;
            mem_waddr = tcw_pkg::cell_index(r_row, r_col);
        end else if (i_cmd.scroll_step && (r_cnt != '0)) begin
            mem_we    = 1'b1;
            mem_waddr = r_cnt - tcw_pkg::IDX_W'(1);
            mem_wdata = r_rd;
        end else if (i_cmd.fill_step) begin
            mem_we    = 1'b1;
            mem_wdata = i_cmd.fill_reset_blank
                ? {tcw_pkg::RESET_BLANK_BG, tcw_pkg::RESET_BLANK_FG, tcw_pkg::CODE_SPACE}
                : {r_blank_bg, r_blank_fg, tcw_pkg::CODE_SPACE};
        end
    end

    // Memory read port: scroll source row or a cell read
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_ridx;
        if (i_cmd.scroll_step && (r_cnt < tcw_pkg::IDX_W'(tcw_pkg::SCROLL_CELLS))) begin
            mem_re    = 1'b1;
            mem_raddr = r_cnt + tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
        end else if (i_cmd.issue_read && read_ok) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= r_screen[mem_raddr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pos  <= tcw_pkg::cell_index(r_row, r_col);
            r_out_col  <= r_col;
            r_out_line <= r_row;
            if ((r_op == tcw_pkg::OP_READ) && read_ok) begin
                r_out_char <= r_rd[tcw_pkg::CHAR_W-1:0];
                r_out_fg   <= r_rd[tcw_pkg::CHAR_W +: tcw_pkg::CLR_W];
                r_out_bg   <= r_rd[tcw_pkg::CHAR_W+tcw_pkg::CLR_W +: tcw_pkg::CLR_W];
            end else begin
                r_out_char <= '0;
                r_out_fg   <= '0;
                r_out_bg   <= '0;
            end
        end
    end

    assign o_cursor_addr = r_out_pos;
    assign o_cursor_col  = r_out_col;
    assign o_cursor_line = r_out_line;
    assign o_read_char   = r_out_char;
    assign o_read_fg     = r_out_fg;
    assign o_read_bg     = r_out_bg;

    // Status to the controller
    assign o_sts.op          = r_op;
    assign o_sts.need_scroll = need_scroll;
    assign o_sts.scroll_end  = (r_cnt == tcw_pkg::IDX_W'(tcw_pkg::SCROLL_CELLS));
    assign o_sts.fill_end    = (r_cnt == tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1));

endmodule

// ===== hdl/tcw_controller.sv =====
// ----------------------------------------------------------------------------
// tcw_controller
// Sequencer for the text console writer: reset sweep, per-transaction
// execution, scroll and fill sweeps, and the result handshake.
// ----------------------------------------------------------------------------
module tcw_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.fill_step        = 1'b1;
                o_cmd.fill_reset_blank = 1'b1;
                if (i_sts.fill_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    tcw_pkg::OP_PUT: begin
                        o_cmd.exec_put = 1'b1;
                        if (i_sts.need_scroll) begin
                            o_cmd.cnt_zero = 1'b1;
                            n_state        = S_SCROLL;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    tcw_pkg::OP_CLEAR: begin
                        o_cmd.clear_cursor = 1'b1;
                        o_cmd.cnt_zero     = 1'b1;
                        n_state            = S_FILL;
                    end
                    tcw_pkg::OP_READ: begin
                        o_cmd.issue_read = 1'b1;
                        n_state          = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCROLL: begin
                // Copy rows up; the counter stays at the bottom row start
                o_cmd.scroll_step = 1'b1;
                if (i_sts.scroll_end) begin
                    n_state = S_FILL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [tcw_pkg::IDX_W-1:0] o_cursor_addr,
    input logic [tcw_pkg::COL_W-1:0] o_cursor_col,
    input logic [tcw_pkg::ROW_W-1:0] o_cursor_line
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_addr))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
                     && (o_cursor_line < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
        else $error("cursor off screen");

    // Linear address agrees with row and column
    a_cursor_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_addr ==
            tcw_pkg::IDX_W'(tcw_pkg::IDX_W'(o_cursor_line) * tcw_pkg::IDX_W'(tcw_pkg::COLUMNS)
                            + tcw_pkg::IDX_W'(o_cursor_col)))
        else $error("cursor address mismatch");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
